// File: rtl/sitp_pkg.sv
// Shared types and constants for the signed integer to decimal text converter.
package sitp_pkg;

    localparam int unsigned VALUE_W = 32;
    localparam int unsigned WIDTH_W = 7;
    localparam int unsigned CODE_W = 7;
    localparam int unsigned DIGIT_W = 4;
    localparam int unsigned NUM_DIGITS = 10;
    localparam int unsigned DIGIT_IDX_W = 4;
    localparam int unsigned LEN_W = 4;
    localparam int unsigned SHIFT_CNT_W = 5;

    localparam logic [CODE_W-1:0] CODE_SPACE = 7'd32;
    localparam logic [CODE_W-1:0] CODE_MINUS = 7'd45;
    localparam logic [CODE_W-1:0] CODE_ZERO = 7'd48;
    localparam logic [CODE_W-1:0] CODE_NONE = 7'd0;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONVERT,
        ST_LENGTH,
        ST_EMIT,
        ST_ERROR
    } sitp_state_t;

    typedef struct packed {
        logic clear;
        logic shift;
    } sitp_cell_ctrl_t;

endpackage

// File: rtl/signed_int_to_padded_decimal_text_top.sv
// Top level of the signed integer to right-justified decimal text converter.
// One input transfer is shifted bit-serially through the chain of ten BCD digit cells,
// the text length is then measured, and then max(min_width, text length) characters
// are emitted, one per cycle while the result side does not stall. A width above
// MAX_WIDTH skips conversion and gives a single error transfer instead. A new input is
// taken as soon as the last character of the previous item sits in the output register.
module signed_int_to_padded_decimal_text_top #(
    parameter int unsigned MAX_WIDTH = 32
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic signed [sitp_pkg::VALUE_W-1:0] s_value,
    input  logic [sitp_pkg::WIDTH_W-1:0]    s_min_width,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [sitp_pkg::CODE_W-1:0]     m_char_code,
    output logic                            m_last,
    output logic                            m_too_wide
);

    localparam logic [sitp_pkg::WIDTH_W-1:0] MAX_WIDTH_C = sitp_pkg::WIDTH_W'(MAX_WIDTH);

    sitp_pkg::sitp_state_t state_reg, state_next;
    sitp_pkg::sitp_cell_ctrl_t cell_ctrl;

    logic [sitp_pkg::VALUE_W-1:0] mag_reg, mag_next;
    logic neg_reg, neg_next;
    logic [sitp_pkg::WIDTH_W-1:0] width_reg, width_next;
    logic [sitp_pkg::SHIFT_CNT_W-1:0] shift_cnt_reg, shift_cnt_next;
    logic [sitp_pkg::LEN_W-1:0] len_reg, len_next;
    logic [sitp_pkg::WIDTH_W-1:0] total_reg, total_next;
    logic [sitp_pkg::WIDTH_W-1:0] pos_reg, pos_next;

    logic m_valid_reg, m_valid_next;
    logic [sitp_pkg::CODE_W-1:0] m_char_code_reg, m_char_code_next;
    logic m_last_reg, m_last_next;
    logic m_too_wide_reg, m_too_wide_next;

    logic in_xfer;
    logic out_free;
    logic too_wide_in;
    logic emit_last;
    logic [sitp_pkg::CODE_W-1:0] emit_code;
    logic [sitp_pkg::LEN_W-1:0] ndig;
    logic [sitp_pkg::LEN_W-1:0] len_calc;
    logic [sitp_pkg::WIDTH_W-1:0] pad;
    logic [sitp_pkg::WIDTH_W-1:0] digit_pos;
    logic [sitp_pkg::DIGIT_W-1:0] digit_sel;

    logic [sitp_pkg::DIGIT_W-1:0] digit_w [sitp_pkg::NUM_DIGITS];
    logic chain_w [sitp_pkg::NUM_DIGITS+1];

    assign chain_w[0] = mag_reg[sitp_pkg::VALUE_W-1];

    for (genvar gi = 0; gi < sitp_pkg::NUM_DIGITS; gi++) begin : g_cells
        sitp_digit_cell u_cell (
            .aclk    (aclk),
            .ctrl    (cell_ctrl),
            .bit_in  (chain_w[gi]),
            .bit_out (chain_w[gi+1]),
            .digit   (digit_w[gi])
        );
    end

    assign in_xfer = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign too_wide_in = s_min_width > MAX_WIDTH_C;

    always_comb begin
        ndig = sitp_pkg::LEN_W'(1);
        for (int i = 1; i < sitp_pkg::NUM_DIGITS; i++) begin
            if (digit_w[i] != '0) begin
                ndig = sitp_pkg::LEN_W'(i + 1);
            end
        end
        len_calc = ndig + sitp_pkg::LEN_W'(neg_reg);
    end

    always_comb begin
        pad = total_reg - sitp_pkg::WIDTH_W'(len_reg);
        digit_pos = total_reg - sitp_pkg::WIDTH_W'(1) - pos_reg;
        if (digit_pos < sitp_pkg::WIDTH_W'(sitp_pkg::NUM_DIGITS)) begin
            digit_sel = digit_w[digit_pos[sitp_pkg::DIGIT_IDX_W-1:0]];
        end else begin
            digit_sel = '0;
        end
        if (pos_reg < pad) begin
            emit_code = sitp_pkg::CODE_SPACE;
        end else if (neg_reg && (pos_reg == pad)) begin
            emit_code = sitp_pkg::CODE_MINUS;
        end else begin
            emit_code = sitp_pkg::CODE_ZERO + sitp_pkg::CODE_W'(digit_sel);
        end
        emit_last = (pos_reg + sitp_pkg::WIDTH_W'(1)) == total_reg;
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            sitp_pkg::ST_IDLE: begin
                if (in_xfer) begin
                    state_next = too_wide_in ? sitp_pkg::ST_ERROR : sitp_pkg::ST_CONVERT;
                end
            end
            sitp_pkg::ST_CONVERT: begin
                if (shift_cnt_reg == '1) begin
                    state_next = sitp_pkg::ST_LENGTH;
                end
            end
            sitp_pkg::ST_LENGTH: begin
                state_next = sitp_pkg::ST_EMIT;
            end
            sitp_pkg::ST_EMIT: begin
                if (out_free && emit_last) begin
                    state_next = sitp_pkg::ST_IDLE;
                end
            end
            sitp_pkg::ST_ERROR: begin
                if (out_free) begin
                    state_next = sitp_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = sitp_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        s_ready = 1'b0;
        cell_ctrl = '0;
        mag_next = mag_reg;
        neg_next = neg_reg;
        width_next = width_reg;
        shift_cnt_next = shift_cnt_reg;
        len_next = len_reg;
        total_next = total_reg;
        pos_next = pos_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_char_code_next = m_char_code_reg;
        m_last_next = m_last_reg;
        m_too_wide_next = m_too_wide_reg;
        unique case (state_reg)
            sitp_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (in_xfer) begin
                    cell_ctrl.clear = 1'b1;
                    neg_next = s_value[sitp_pkg::VALUE_W-1];
                    mag_next = s_value[sitp_pkg::VALUE_W-1] ? (~s_value + 1'b1) : s_value;
                    width_next = s_min_width;
                    shift_cnt_next = '0;
                end
            end
            sitp_pkg::ST_CONVERT: begin
                cell_ctrl.shift = 1'b1;
                mag_next = {mag_reg[sitp_pkg::VALUE_W-2:0], 1'b0};
                shift_cnt_next = shift_cnt_reg + 1'b1;
            end
            sitp_pkg::ST_LENGTH: begin
                len_next = len_calc;
                total_next = (width_reg > sitp_pkg::WIDTH_W'(len_calc)) ?
                             width_reg : sitp_pkg::WIDTH_W'(len_calc);
                pos_next = '0;
            end
            sitp_pkg::ST_EMIT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_char_code_next = emit_code;
                    m_last_next = emit_last;
                    m_too_wide_next = 1'b0;
                    pos_next = pos_reg + 1'b1;
                end
            end
            sitp_pkg::ST_ERROR: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_char_code_next = sitp_pkg::CODE_NONE;
                    m_last_next = 1'b1;
                    m_too_wide_next = 1'b1;
                end
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= sitp_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        mag_reg <= mag_next;
        neg_reg <= neg_next;
        width_reg <= width_next;
        shift_cnt_reg <= shift_cnt_next;
        len_reg <= len_next;
        total_reg <= total_next;
        pos_reg <= pos_next;
        m_char_code_reg <= m_char_code_next;
        m_last_reg <= m_last_next;
        m_too_wide_reg <= m_too_wide_next;
    end

    assign m_valid = m_valid_reg;
    assign m_char_code = m_char_code_reg;
    assign m_last = m_last_reg;
    assign m_too_wide = m_too_wide_reg;

    // An error transfer carries no character and always ends the item.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_too_wide) |-> (m_last && (m_char_code == sitp_pkg::CODE_NONE)))
        else $error("error transfer without last flag or with a character");

    // The emitted field never exceeds the configured bound.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == sitp_pkg::ST_EMIT) |->
        ((total_reg <= MAX_WIDTH_C) && (total_reg != '0) && (pos_reg < total_reg)))
        else $error("character position outside the field");

    // Cells 0 and 5 hold a decimal digit and cell 9 at most 2 after the shifting.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == sitp_pkg::ST_LENGTH) |->
        ((digit_w[0] <= 4'd9) && (digit_w[5] <= 4'd9) && (digit_w[9] <= 4'd2)))
        else $error("digit cell out of decimal range after conversion");

    // A conversion in progress never takes a new input.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != sitp_pkg::ST_IDLE) |-> !s_ready)
        else $error("input accepted during a conversion");

endmodule

// File: rtl/sitp_digit_cell.sv
// One BCD digit cell of the shift-and-add-3 conversion chain.
module sitp_digit_cell (
    input  logic                           aclk,
    input  sitp_pkg::sitp_cell_ctrl_t      ctrl,
    input  logic                           bit_in,
    output logic                           bit_out,
    output logic [sitp_pkg::DIGIT_W-1:0]   digit
);

    logic [sitp_pkg::DIGIT_W-1:0] digit_reg;
    logic [sitp_pkg::DIGIT_W-1:0] digit_next;
    logic [sitp_pkg::DIGIT_W-1:0] adjusted;

    always_comb begin
        if (digit_reg >= 4'd5) begin
            adjusted = digit_reg + 4'd3;
        end else begin
            adjusted = digit_reg;
        end
        digit_next = {adjusted[2:0], bit_in};
    end

    always_ff @(posedge aclk) begin
        if (ctrl.clear) begin
            digit_reg <= '0;
        end else if (ctrl.shift) begin
            digit_reg <= digit_next;
        end
    end

    assign bit_out = adjusted[3];
    assign digit = digit_reg;

endmodule

// File: sim/signed_int_to_padded_decimal_text_top_test.sv
// Testbench for the signed integer to right-justified decimal text converter.
`timescale 1ns / 100ps

module signed_int_to_padded_decimal_text_top_test;

    localparam int unsigned MAX_WIDTH = 32;
    localparam int unsigned CLK_PERIOD = 10;
    localparam int unsigned RESET_CYCLES = 12;
    localparam int unsigned ROW_COUNT = 24;
    localparam int unsigned RANDOM_ITEMS = 386;
    localparam int unsigned TOTAL_ITEMS = ROW_COUNT + RANDOM_ITEMS;
    localparam int unsigned CALM_ITEMS = 40;
    localparam int unsigned HOLD_AT = 100;
    localparam int unsigned HOLD_CYCLES = 400;
    localparam int unsigned DRAIN_CYCLES = 80;
    localparam int unsigned LIMIT_NS = 20_000_000;
    localparam int unsigned REPORT_LIMIT = 10;

    typedef struct packed {
        logic [sitp_pkg::CODE_W-1:0] code;
        logic                        last;
        logic                        too_wide;
    } text_char_t;

    typedef enum logic [1:0] {
        BY_MODEL,
        BY_TEXT,
        BY_ERROR
    } row_check_t;

    typedef struct packed {
        logic [sitp_pkg::VALUE_W-1:0] value;
        logic [sitp_pkg::WIDTH_W-1:0] min_width;
        row_check_t                   check;
    } text_row_t;

    logic                                aclk = 1'b0;
    logic                                aresetn = 1'b0;
    logic                                s_valid = 1'b0;
    logic                                s_ready;
    logic signed [sitp_pkg::VALUE_W-1:0] s_value = '0;
    logic [sitp_pkg::WIDTH_W-1:0]        s_min_width = '0;
    logic                                m_valid;
    logic                                m_ready = 1'b0;
    logic [sitp_pkg::CODE_W-1:0]         m_char_code;
    logic                                m_last;
    logic                                m_too_wide;

    text_char_t  text_chars[$];
    text_char_t  chars_due[$];
    int unsigned items_sent = 0;
    int unsigned fail_count = 0;

    text_row_t rows [ROW_COUNT] = '{
        '{32'd0,          7'd0,   BY_TEXT},
        '{32'd0,          7'd1,   BY_TEXT},
        '{32'h7FFFFFFF,   7'd0,   BY_TEXT},
        '{32'h80000000,   7'd0,   BY_TEXT},
        '{32'h80000000,   7'd11,  BY_TEXT},
        '{32'h80000000,   7'd12,  BY_TEXT},
        '{32'hFFFFFFFF,   7'd0,   BY_TEXT},
        '{32'd1,          7'd32,  BY_MODEL},
        '{32'hFFFFFFF9,   7'd32,  BY_MODEL},
        '{32'd5,          7'd33,  BY_ERROR},
        '{32'd0,          7'd127, BY_ERROR},
        '{32'h80000000,   7'd127, BY_ERROR},
        '{32'd12345,      7'd3,   BY_TEXT},
        '{32'd12345,      7'd5,   BY_TEXT},
        '{32'd12345,      7'd6,   BY_TEXT},
        '{32'hFFFFFFD6,   7'd5,   BY_TEXT},
        '{32'd1000000000, 7'd10,  BY_TEXT},
        '{32'd9,          7'd2,   BY_TEXT},
        '{32'd10,         7'd0,   BY_TEXT},
        '{32'h55555555,   7'd21,  BY_MODEL},
        '{32'hAAAAAAAA,   7'd42,  BY_ERROR},
        '{32'd99,         7'd31,  BY_MODEL},
        '{32'h7FFFFFFF,   7'd32,  BY_MODEL},
        '{32'hFFFFFFFF,   7'd85,  BY_ERROR}
    };

    string row_text [ROW_COUNT] = '{
        "0", "0", "2147483647", "-2147483648", "-2147483648", " -2147483648", "-1",
        "", "", "", "", "",
        "12345", "12345", " 12345", "  -42", "1000000000", " 9", "10",
        "", "", "", "", ""
    };

    signed_int_to_padded_decimal_text_top #(
        .MAX_WIDTH(MAX_WIDTH)
    ) u_top (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_value(s_value),
        .s_min_width(s_min_width),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_char_code(m_char_code),
        .m_last(m_last),
        .m_too_wide(m_too_wide)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    function automatic void add_char(input logic [sitp_pkg::CODE_W-1:0] code,
                                     input int total);
        text_chars.push_back('{code, (text_chars.size() + 1 == total), 1'b0});
    endfunction

    function automatic void add_error();
        text_chars.push_back('{sitp_pkg::CODE_NONE, 1'b1, 1'b1});
    endfunction

    function automatic void format_decimal(input logic [sitp_pkg::VALUE_W-1:0] value,
                                           input logic [sitp_pkg::WIDTH_W-1:0] min_width);
        logic                         neg;
        logic [sitp_pkg::VALUE_W-1:0] mag;
        logic [sitp_pkg::DIGIT_W-1:0] digits [11];
        int                           n_digits;
        int                           text_len;
        int                           total;
        text_chars.delete();
        if (min_width > MAX_WIDTH) begin
            add_error();
            return;
        end
        neg = value[sitp_pkg::VALUE_W-1];
        mag = neg ? ~value + 1'b1 : value;
        n_digits = 0;
        do begin
            digits[n_digits] = sitp_pkg::DIGIT_W'(mag % 10);
            mag = mag / 10;
            n_digits++;
        end while (mag != 0);
        text_len = n_digits + int'(neg);
        total = (int'(min_width) > text_len) ? int'(min_width) : text_len;
        for (int p = 0; p < total - text_len; p++) begin
            add_char(sitp_pkg::CODE_SPACE, total);
        end
        if (neg) begin
            add_char(sitp_pkg::CODE_MINUS, total);
        end
        for (int i = n_digits - 1; i >= 0; i--) begin
            add_char(sitp_pkg::CODE_ZERO + sitp_pkg::CODE_W'(digits[i]), total);
        end
    endfunction

    function automatic void spell_out(input string text);
        byte ch;
        text_chars.delete();
        for (int i = 0; i < text.len(); i++) begin
            ch = text[i];
            add_char(ch[sitp_pkg::CODE_W-1:0], text.len());
        end
    endfunction

    function automatic bit idling_on();
        return (items_sent + CALM_ITEMS < TOTAL_ITEMS) && ((items_sent / 50) % 4 != 3);
    endfunction

    function automatic logic [sitp_pkg::VALUE_W-1:0] pick_value();
        logic [sitp_pkg::VALUE_W-1:0] v;
        int unsigned                  kind;
        int unsigned                  k;
        kind = $urandom_range(0, 5);
        case (kind)
            0: begin
                v = $urandom_range(0, 999);
            end
            1: begin
                v = 1;
                k = $urandom_range(0, 9);
                repeat (k) v = v * 10;
                v = v - $urandom_range(0, 1);
            end
            2: begin
                case ($urandom_range(0, 3))
                    0: v = 32'h80000000;
                    1: v = 32'h7FFFFFFF;
                    2: v = 32'h00000000;
                    default: v = 32'hFFFFFFFF;
                endcase
            end
            default: begin
                v = $urandom();
            end
        endcase
        if (kind < 2 && $urandom_range(0, 1) == 1) begin
            v = ~v + 1'b1;
        end
        return v;
    endfunction

    function automatic logic [sitp_pkg::WIDTH_W-1:0] pick_width();
        case ($urandom_range(0, 9))
            0: return sitp_pkg::WIDTH_W'($urandom_range(MAX_WIDTH + 1, 127));
            1: return sitp_pkg::WIDTH_W'($urandom_range(0, 127));
            2, 3: return sitp_pkg::WIDTH_W'($urandom_range(0, MAX_WIDTH));
            default: return sitp_pkg::WIDTH_W'($urandom_range(0, 12));
        endcase
    endfunction

    task automatic offer_item(input logic [sitp_pkg::VALUE_W-1:0] value,
                              input logic [sitp_pkg::WIDTH_W-1:0] min_width);
        s_value <= value;
        s_min_width <= min_width;
        s_valid <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        foreach (text_chars[i]) chars_due.push_back(text_chars[i]);
        items_sent++;
        if (idling_on() && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge aclk);
        end
    endtask

    task automatic note_failure(input string what);
        fail_count++;
        if (fail_count <= REPORT_LIMIT) begin
            $display("%0t: %s", $time, what);
        end
    endtask

    always @(posedge aclk) begin
        text_char_t want;
        if (aresetn && m_valid && m_ready) begin
            if (chars_due.size() == 0) begin
                note_failure($sformatf("unexpected transfer: code %0d last %0b too_wide %0b",
                                       m_char_code, m_last, m_too_wide));
            end else begin
                want = chars_due.pop_front();
                if (m_char_code !== want.code || m_last !== want.last
                        || m_too_wide !== want.too_wide) begin
                    note_failure($sformatf(
                        "mismatch: expected code %0d last %0b too_wide %0b, got %0d %0b %0b",
                        want.code, want.last, want.too_wide,
                        m_char_code, m_last, m_too_wide));
                end
            end
        end
    end

    initial begin : result_sink
        int unsigned sink_gap;
        bit          held;
        sink_gap = 0;
        held = 1'b0;
        forever begin
            @(posedge aclk);
            if (!held && items_sent >= HOLD_AT) begin
                held = 1'b1;
                sink_gap = HOLD_CYCLES;
            end else if (sink_gap == 0 && idling_on() && $urandom_range(0, 7) == 0) begin
                sink_gap = $urandom_range(1, 15);
            end
            if (sink_gap != 0) begin
                m_ready <= 1'b0;
                sink_gap--;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    initial begin
        #(LIMIT_NS);
        $display("signed_int_to_padded_decimal_text_top test failed");
        $finish;
    end

    initial begin
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int r = 0; r < ROW_COUNT; r++) begin
            case (rows[r].check)
                BY_TEXT: spell_out(row_text[r]);
                BY_ERROR: begin
                    text_chars.delete();
                    add_error();
                end
                default: format_decimal(rows[r].value, rows[r].min_width);
            endcase
            offer_item(rows[r].value, rows[r].min_width);
        end

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            logic [sitp_pkg::VALUE_W-1:0] value;
            logic [sitp_pkg::WIDTH_W-1:0] min_width;
            value = pick_value();
            min_width = pick_width();
            format_decimal(value, min_width);
            offer_item(value, min_width);
        end
        s_valid <= 1'b0;

        while (chars_due.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (fail_count == 0) begin
            $display("signed_int_to_padded_decimal_text_top test passed");
        end else begin
            $display("signed_int_to_padded_decimal_text_top test failed");
        end
        $finish;
    end

endmodule
